// ===== rtl/alurf_pkg.sv =====
// Shared definitions for the eight-bit ALU register file: widths, action and
// status codes, control word layout, dispatch table and microcode ROM.
// No dependencies.
`default_nettype none

package alurf_pkg;

  localparam int DATA_W     = 8;
  localparam int ACTION_W   = 5;
  localparam int REG_A_W    = 3;
  localparam int FLAGS_W    = 3;
  localparam int STATUS_W   = 2;
  localparam int REG_COUNT  = 8;
  localparam int REG_IDX_W  = $clog2(REG_COUNT);
  localparam int DIV_CNT_W  = $clog2(DATA_W);
  localparam int UADDR_W    = 5;

  localparam logic [ACTION_W-1:0] ACT_CMP  = 5'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD  = 5'd1;
  localparam logic [ACTION_W-1:0] ACT_ADDI = 5'd2;
  localparam logic [ACTION_W-1:0] ACT_SUB  = 5'd3;
  localparam logic [ACTION_W-1:0] ACT_INC  = 5'd4;
  localparam logic [ACTION_W-1:0] ACT_DEC  = 5'd5;
  localparam logic [ACTION_W-1:0] ACT_MUL  = 5'd6;
  localparam logic [ACTION_W-1:0] ACT_DIV  = 5'd7;
  localparam logic [ACTION_W-1:0] ACT_MOD  = 5'd8;
  localparam logic [ACTION_W-1:0] ACT_NOT  = 5'd9;
  localparam logic [ACTION_W-1:0] ACT_AND  = 5'd10;
  localparam logic [ACTION_W-1:0] ACT_OR   = 5'd11;
  localparam logic [ACTION_W-1:0] ACT_XOR  = 5'd12;
  localparam logic [ACTION_W-1:0] ACT_SHL  = 5'd13;
  localparam logic [ACTION_W-1:0] ACT_SHR  = 5'd14;
  localparam logic [ACTION_W-1:0] ACT_LOAD = 5'd15;

  localparam logic [FLAGS_W-1:0] FLAG_EQUAL   = 3'b001;
  localparam logic [FLAGS_W-1:0] FLAG_GREATER = 3'b010;
  localparam logic [FLAGS_W-1:0] FLAG_LESS    = 3'b100;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_DIVZ   = 2'd1,
    STATUS_UNIMPL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    RS_NONE, RS_ADD, RS_ADDI, RS_SUB, RS_INC, RS_DEC, RS_MUL, RS_NOT,
    RS_AND, RS_OR, RS_XOR, RS_SHL, RS_SHR, RS_IMM, RS_QUO, RS_REM
  } res_sel_t;

  typedef enum logic [1:0] {
    DIV_HOLD, DIV_INIT, DIV_STEP
  } div_op_t;

  typedef enum logic [1:0] {
    J_NONE, J_BZERO, J_LOOP
  } jump_t;

  typedef enum logic {
    ST_IDLE, ST_RUN
  } state_t;

  typedef logic [UADDR_W-1:0] uaddr_t;

  typedef struct packed {
    res_sel_t sel;
    logic     wr;
    logic     flag_wr;
    status_t  status;
    div_op_t  div;
    jump_t    jmp;
    uaddr_t   target;
    logic     done;
  } uword_t;

  localparam uaddr_t UA_CMP     = 5'd1;
  localparam uaddr_t UA_ADD     = 5'd2;
  localparam uaddr_t UA_ADDI    = 5'd3;
  localparam uaddr_t UA_SUB     = 5'd4;
  localparam uaddr_t UA_INC     = 5'd5;
  localparam uaddr_t UA_DEC     = 5'd6;
  localparam uaddr_t UA_MUL     = 5'd7;
  localparam uaddr_t UA_NOT     = 5'd8;
  localparam uaddr_t UA_AND     = 5'd9;
  localparam uaddr_t UA_OR      = 5'd10;
  localparam uaddr_t UA_XOR     = 5'd11;
  localparam uaddr_t UA_SHL     = 5'd12;
  localparam uaddr_t UA_SHR     = 5'd13;
  localparam uaddr_t UA_LOAD    = 5'd14;
  localparam uaddr_t UA_BAD     = 5'd15;
  localparam uaddr_t UA_DIVCHK  = 5'd16;
  localparam uaddr_t UA_DIVLOOP = 5'd17;
  localparam uaddr_t UA_DIVWB   = 5'd18;
  localparam uaddr_t UA_MODCHK  = 5'd19;
  localparam uaddr_t UA_MODLOOP = 5'd20;
  localparam uaddr_t UA_MODWB   = 5'd21;
  localparam uaddr_t UA_DIVZERO = 5'd22;

  function automatic uaddr_t dispatch(logic [ACTION_W-1:0] act);
    uaddr_t a;
    case (act)
      ACT_CMP:  a = UA_CMP;
      ACT_ADD:  a = UA_ADD;
      ACT_ADDI: a = UA_ADDI;
      ACT_SUB:  a = UA_SUB;
      ACT_INC:  a = UA_INC;
      ACT_DEC:  a = UA_DEC;
      ACT_MUL:  a = UA_MUL;
      ACT_DIV:  a = UA_DIVCHK;
      ACT_MOD:  a = UA_MODCHK;
      ACT_NOT:  a = UA_NOT;
      ACT_AND:  a = UA_AND;
      ACT_OR:   a = UA_OR;
      ACT_XOR:  a = UA_XOR;
      ACT_SHL:  a = UA_SHL;
      ACT_SHR:  a = UA_SHR;
      ACT_LOAD: a = UA_LOAD;
      default:  a = UA_BAD;
    endcase
    return a;
  endfunction

  function automatic uword_t uw_exec(res_sel_t sel);
    return '{sel: sel, wr: 1'b1, flag_wr: 1'b0, status: STATUS_OK, div: DIV_HOLD,
             jmp: J_NONE, target: '0, done: 1'b1};
  endfunction

  function automatic uword_t urom(uaddr_t addr);
    uword_t w;
    w = '{sel: RS_NONE, wr: 1'b0, flag_wr: 1'b0, status: STATUS_UNIMPL,
          div: DIV_HOLD, jmp: J_NONE, target: '0, done: 1'b1};
    case (addr)
      UA_CMP: begin
        w.flag_wr = 1'b1;
        w.status  = STATUS_OK;
      end
      UA_ADD:     w = uw_exec(RS_ADD);
      UA_ADDI:    w = uw_exec(RS_ADDI);
      UA_SUB:     w = uw_exec(RS_SUB);
      UA_INC:     w = uw_exec(RS_INC);
      UA_DEC:     w = uw_exec(RS_DEC);
      UA_MUL:     w = uw_exec(RS_MUL);
      UA_NOT:     w = uw_exec(RS_NOT);
      UA_AND:     w = uw_exec(RS_AND);
      UA_OR:      w = uw_exec(RS_OR);
      UA_XOR:     w = uw_exec(RS_XOR);
      UA_SHL:     w = uw_exec(RS_SHL);
      UA_SHR:     w = uw_exec(RS_SHR);
      UA_LOAD:    w = uw_exec(RS_IMM);
      UA_DIVCHK, UA_MODCHK: begin
        w.status = STATUS_OK;
        w.div    = DIV_INIT;
        w.jmp    = J_BZERO;
        w.target = UA_DIVZERO;
        w.done   = 1'b0;
      end
      UA_DIVLOOP, UA_MODLOOP: begin
        w.status = STATUS_OK;
        w.div    = DIV_STEP;
        w.jmp    = J_LOOP;
        w.done   = 1'b0;
      end
      UA_DIVWB:   w = uw_exec(RS_QUO);
      UA_MODWB:   w = uw_exec(RS_REM);
      UA_DIVZERO: w.status = STATUS_DIVZ;
      default: ;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alurf_in_if.sv =====
// Command channel: valid/ready handshake carrying action, reg_a, operand_b.
// Depends on alurf_pkg for field widths.
`default_nettype none

interface alurf_in_if;
  logic                            valid;
  logic                            ready;
  logic [alurf_pkg::ACTION_W-1:0]  action;
  logic [alurf_pkg::REG_A_W-1:0]   reg_a;
  logic [alurf_pkg::DATA_W-1:0]    operand_b;

  modport source (output valid, action, reg_a, operand_b, input ready);
  modport sink   (input valid, action, reg_a, operand_b, output ready);
endinterface

`default_nettype wire

// ===== rtl/alurf_out_if.sv =====
// Result channel: valid/ready handshake carrying result_value, wrote, flags, status.
// Depends on alurf_pkg for field widths.
`default_nettype none

interface alurf_out_if;
  logic                            valid;
  logic                            ready;
  logic [alurf_pkg::DATA_W-1:0]    result_value;
  logic                            wrote;
  logic [alurf_pkg::FLAGS_W-1:0]   flags;
  logic [alurf_pkg::STATUS_W-1:0]  status;

  modport source (output valid, result_value, wrote, flags, status, input ready);
  modport sink   (input valid, result_value, wrote, flags, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/eight_bit_alu_register_file.sv =====
// Top level: microcoded ALU over an eight-entry, eight-bit register file.
// Depends on alurf_pkg, alurf_in_if, alurf_out_if and alurf_divider.
//
// Usage:
//   cmd carries one action with reg_a and operand_b; rsp returns one result
//   (result_value, wrote, flags, status) for every accepted command.
//   A command is taken when cmd.valid and cmd.ready are high at a clock edge.
//   The operands are read from the register file at that edge, then the
//   microcode ROM runs one control word per cycle from the dispatch address,
//   except that the final word holds while rsp stalls. Single-word actions
//   commit with their one control word; divide and modulo run a check word,
//   eight divider steps and a writeback word; divide or modulo by zero runs
//   the check word and then the divide-by-zero word. The iterative divider
//   loop keeps divide and modulo in flight longest.
//   cmd.ready is low while a command is in flight; the next command can be
//   taken while the previous result still waits on rsp.
//   If rsp stalls, the final control word holds until the output register
//   is free; register file and flags are committed with the result.
//   Synchronous reset clears the register file, the flags and the
//   sequencer; no result is pending after reset.
`default_nettype none

module eight_bit_alu_register_file (
  input  wire logic   clk,
  input  wire logic   rst,
  alurf_in_if.sink    cmd,
  alurf_out_if.source rsp
);

  logic [alurf_pkg::DATA_W-1:0]    rf [alurf_pkg::REG_COUNT];
  logic [alurf_pkg::FLAGS_W-1:0]   flag_reg;

  alurf_pkg::state_t               state, state_next;
  alurf_pkg::uaddr_t               upc;
  alurf_pkg::uword_t               uw;

  logic [alurf_pkg::REG_IDX_W-1:0] idx_a;
  logic [alurf_pkg::DATA_W-1:0]    a_op;
  logic [alurf_pkg::DATA_W-1:0]    b_op;
  logic [alurf_pkg::DATA_W-1:0]    imm;

  logic [alurf_pkg::DATA_W-1:0]    quo;
  logic [alurf_pkg::DATA_W-1:0]    rem;
  logic                            div_last;
  alurf_pkg::div_op_t              div_op;

  logic                            cmd_xfer;
  logic                            out_free;
  logic                            commit;
  logic [alurf_pkg::DATA_W-1:0]    res;
  logic [2*alurf_pkg::DATA_W-1:0]  prod;
  logic [alurf_pkg::FLAGS_W-1:0]   cmp_flags;

  logic                            out_valid;
  logic [alurf_pkg::DATA_W-1:0]    out_value;
  logic                            out_wrote;
  logic [alurf_pkg::FLAGS_W-1:0]   out_flags;
  alurf_pkg::status_t              out_status;

  assign uw       = alurf_pkg::urom(upc);
  assign cmd_xfer = cmd.valid && cmd.ready;
  assign out_free = !out_valid || rsp.ready;
  assign div_op   = (state == alurf_pkg::ST_RUN) ? uw.div : alurf_pkg::DIV_HOLD;

  alurf_divider u_div (
    .clk      (clk),
    .op       (div_op),
    .dividend (a_op),
    .divisor  (b_op),
    .quo      (quo),
    .rem      (rem),
    .last     (div_last)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alurf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    commit     = 1'b0;
    case (state)
      alurf_pkg::ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = alurf_pkg::ST_RUN;
        end
      end
      alurf_pkg::ST_RUN: begin
        if (uw.done && out_free) begin
          commit     = 1'b1;
          state_next = alurf_pkg::ST_IDLE;
        end
      end
      default: state_next = alurf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= '0;
    end else if (cmd_xfer) begin
      upc <= alurf_pkg::dispatch(cmd.action);
    end else if (state == alurf_pkg::ST_RUN && !uw.done) begin
      case (uw.jmp)
        alurf_pkg::J_BZERO: upc <= (b_op == '0) ? uw.target : upc + 1'b1;
        alurf_pkg::J_LOOP:  upc <= div_last ? upc + 1'b1 : upc;
        default:            upc <= upc + 1'b1;
      endcase
    end
  end

  // Operand read at the command transfer.
  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      idx_a <= cmd.reg_a[alurf_pkg::REG_IDX_W-1:0];
      a_op  <= rf[cmd.reg_a[alurf_pkg::REG_IDX_W-1:0]];
      b_op  <= rf[cmd.operand_b[alurf_pkg::REG_IDX_W-1:0]];
      imm   <= cmd.operand_b;
    end
  end

  assign prod = a_op * b_op;

  always_comb begin
    case (uw.sel)
      alurf_pkg::RS_ADD:  res = a_op + b_op;
      alurf_pkg::RS_ADDI: res = a_op + imm;
      alurf_pkg::RS_SUB:  res = a_op - b_op;
      alurf_pkg::RS_INC:  res = a_op + 1'b1;
      alurf_pkg::RS_DEC:  res = a_op - 1'b1;
      alurf_pkg::RS_MUL:  res = prod[alurf_pkg::DATA_W-1:0];
      alurf_pkg::RS_NOT:  res = ~a_op;
      alurf_pkg::RS_AND:  res = a_op & b_op;
      alurf_pkg::RS_OR:   res = a_op | b_op;
      alurf_pkg::RS_XOR:  res = a_op ^ b_op;
      alurf_pkg::RS_SHL:  res = (b_op[alurf_pkg::DATA_W-1:3] != '0) ? '0 : a_op << b_op[2:0];
      alurf_pkg::RS_SHR:  res = (b_op[alurf_pkg::DATA_W-1:3] != '0) ? '0 : a_op >> b_op[2:0];
      alurf_pkg::RS_IMM:  res = imm;
      alurf_pkg::RS_QUO:  res = quo;
      alurf_pkg::RS_REM:  res = rem;
      default:            res = '0;
    endcase
  end

  always_comb begin
    if (a_op == b_op) begin
      cmp_flags = alurf_pkg::FLAG_EQUAL;
    end else if (a_op > b_op) begin
      cmp_flags = alurf_pkg::FLAG_GREATER;
    end else begin
      cmp_flags = alurf_pkg::FLAG_LESS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < alurf_pkg::REG_COUNT; i++) begin
        rf[i] <= '0;
      end
      flag_reg <= '0;
    end else if (commit) begin
      if (uw.wr) begin
        rf[idx_a] <= res;
      end
      if (uw.flag_wr) begin
        flag_reg <= cmp_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_value  <= uw.wr ? res : '0;
      out_wrote  <= uw.wr;
      out_flags  <= uw.flag_wr ? cmp_flags : flag_reg;
      out_status <= uw.status;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.wrote        = out_wrote;
  assign rsp.flags        = out_flags;
  assign rsp.status       = out_status;

endmodule

`default_nettype wire

// ===== rtl/alurf_divider.sv =====
// Restoring divider, one quotient bit per step, driven by the microcode word.
// Depends on alurf_pkg.
`default_nettype none

module alurf_divider (
  input  wire logic                         clk,
  input  wire alurf_pkg::div_op_t           op,
  input  wire logic [alurf_pkg::DATA_W-1:0] dividend,
  input  wire logic [alurf_pkg::DATA_W-1:0] divisor,
  output logic      [alurf_pkg::DATA_W-1:0] quo,
  output logic      [alurf_pkg::DATA_W-1:0] rem,
  output logic                              last
);

  logic [alurf_pkg::DIV_CNT_W-1:0] cnt;
  logic [alurf_pkg::DATA_W:0]      shifted;
  logic [alurf_pkg::DATA_W:0]      diff;
  logic                            fits;

  assign shifted = {rem, quo[alurf_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = shifted >= {1'b0, divisor};
  assign last    = cnt == {alurf_pkg::DIV_CNT_W{1'b1}};

  always_ff @(posedge clk) begin
    case (op)
      alurf_pkg::DIV_INIT: begin
        quo <= dividend;
        rem <= '0;
        cnt <= '0;
      end
      alurf_pkg::DIV_STEP: begin
        quo <= {quo[alurf_pkg::DATA_W-2:0], fits};
        rem <= fits ? diff[alurf_pkg::DATA_W-1:0] : shifted[alurf_pkg::DATA_W-1:0];
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/alurf_checker.sv =====
// Port-level checker for the eight-bit ALU register file, bound to the top level.
// Depends on alurf_pkg for widths and status codes.
`default_nettype none

module alurf_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           cmd_valid,
  input wire logic                           cmd_ready,
  input wire logic                           rsp_valid,
  input wire logic                           rsp_ready,
  input wire logic [alurf_pkg::DATA_W-1:0]   rsp_value,
  input wire logic                           rsp_wrote,
  input wire logic [alurf_pkg::FLAGS_W-1:0]  rsp_flags,
  input wire logic [alurf_pkg::STATUS_W-1:0] rsp_status
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_wrote)
      && $stable(rsp_flags) && $stable(rsp_status))
    else $error("rsp payload changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("second command taken while one is in flight");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_wrote |-> rsp_value == '0)
    else $error("nonzero result without a register write");

  a_error_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != alurf_pkg::STATUS_OK |-> !rsp_wrote)
    else $error("register written on an error status");

  a_cmp_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == alurf_pkg::STATUS_OK && !rsp_wrote |-> $onehot(rsp_flags))
    else $error("compare result without exactly one flag");

endmodule

bind eight_bit_alu_register_file alurf_checker u_alurf_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_value  (rsp.result_value),
  .rsp_wrote  (rsp.wrote),
  .rsp_flags  (rsp.flags),
  .rsp_status (rsp.status)
);

`default_nettype wire
